// File: rtl/i2cme_pkg.sv
// Shared types for the I2C master byte engine.
package i2cme_pkg;

   typedef enum logic [2:0] {
      CMD_IDLE  = 3'd0,
      CMD_START = 3'd1,
      CMD_STOP  = 3'd2,
      CMD_WRITE = 3'd3,
      CMD_READ  = 3'd4
   } cmd_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       ack_seen;
   } rsp_type;

endpackage

// File: rtl/i2cme_core.sv
// Phase sequencer: bus state registers and the per-tick next-state logic.
module i2cme_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  logic              csr_we,
   input  logic [8:0]        csr_wdata,
   input  logic [2:0]        action,
   input  logic [7:0]        tx_byte,
   input  logic              ack_to_send,
   input  logic              sda_in,
   output i2cme_pkg::rsp_type rsp_next
);
   import i2cme_pkg::*;

   localparam logic [8:0] PHASE_TICKS_RESET = 9'd5;
   localparam logic [4:0] LAST_START = 5'd1;
   localparam logic [4:0] LAST_STOP  = 5'd1;
   localparam logic [4:0] LAST_WRITE = 5'd26;
   localparam logic [4:0] LAST_READ  = 5'd18;
   localparam logic [4:0] WR_ACK_LOW  = 5'd24;
   localparam logic [4:0] WR_ACK_HIGH = 5'd25;
   localparam logic [4:0] RD_ACK_LOW  = 5'd16;
   localparam logic [4:0] RD_ACK_HIGH = 5'd17;
   localparam logic [1:0] SUB_LOW  = 2'd0;
   localparam logic [1:0] SUB_DATA = 2'd1;
   localparam logic [1:0] SUB_HIGH = 2'd2;
   localparam logic [1:0] WR_SUB [32] = '{
      2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1,
      2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0,
      2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2,
      2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1
   };

   logic [8:0] pt_ff;
   cmd_type    cmd_ff, cmd_in;
   logic [4:0] ph_ff, ph_in;
   logic [8:0] tc_ff, tc_in;
   logic [7:0] sr_ff, sr_in;
   logic       ack_ff, ack_in;
   logic       clk_ff, clk_in;
   logic       dat_ff, dat_in;
   logic       hold_ff, hold_in;
   logic [7:0] rx_ff, rx_in;
   logic       done;

   always_ff @(posedge clock) begin
      if (reset) begin
         pt_ff   <= PHASE_TICKS_RESET;
         cmd_ff  <= CMD_IDLE;
         ph_ff   <= '0;
         tc_ff   <= '0;
         sr_ff   <= '0;
         ack_ff  <= 1'b1;
         clk_ff  <= 1'b1;
         dat_ff  <= 1'b1;
         hold_ff <= 1'b0;
         rx_ff   <= '0;
      end else begin
         if (csr_we) begin
            pt_ff <= csr_wdata;
         end
         if (step_en) begin
            cmd_ff  <= cmd_in;
            ph_ff   <= ph_in;
            tc_ff   <= tc_in;
            sr_ff   <= sr_in;
            ack_ff  <= ack_in;
            clk_ff  <= clk_in;
            dat_ff  <= dat_in;
            hold_ff <= hold_in;
            rx_ff   <= rx_in;
         end
      end
   end

   always_comb begin
      logic [8:0] len;
      logic [8:0] tc_nx;
      logic [7:0] sr_mid;
      logic [4:0] ph_nx;
      logic [4:0] ph_last;
      len     = (pt_ff == 9'd0) ? 9'd1 : pt_ff;
      tc_nx   = tc_ff + 9'd1;
      sr_mid  = sr_ff;
      ph_nx   = ph_ff + 5'd1;
      cmd_in  = cmd_ff;
      ph_in   = ph_ff;
      tc_in   = tc_ff;
      sr_in   = sr_ff;
      ack_in  = ack_ff;
      clk_in  = clk_ff;
      dat_in  = dat_ff;
      hold_in = hold_ff;
      rx_in   = rx_ff;
      done    = 1'b0;
      unique case (cmd_ff)
         CMD_START: ph_last = LAST_START;
         CMD_STOP:  ph_last = LAST_STOP;
         CMD_WRITE: ph_last = LAST_WRITE;
         CMD_READ:  ph_last = LAST_READ;
         default:   ph_last = '0;
      endcase

      if (cmd_ff == CMD_IDLE) begin
         ph_in = '0;
         tc_in = '0;
         unique case (action)
            CMD_START: begin
               cmd_in = CMD_START;
               sr_in  = '0;
               dat_in = 1'b1;
               clk_in = 1'b1;
            end
            CMD_STOP: begin
               cmd_in = CMD_STOP;
               sr_in  = '0;
               dat_in = 1'b0;
               clk_in = 1'b1;
            end
            CMD_WRITE: begin
               cmd_in = CMD_WRITE;
               sr_in  = tx_byte;
               clk_in = 1'b0;
            end
            CMD_READ: begin
               cmd_in  = CMD_READ;
               sr_in   = '0;
               hold_in = ack_to_send;
               clk_in  = 1'b1;
               dat_in  = 1'b1;
            end
            default: begin
               cmd_in = CMD_IDLE;
            end
         endcase
      end else begin
         tc_in = tc_nx;
         if (tc_nx >= len) begin
            tc_in = '0;
            if (cmd_ff == CMD_WRITE && ph_ff == WR_ACK_HIGH) begin
               ack_in = sda_in;
            end
            if (cmd_ff == CMD_READ && ph_ff < RD_ACK_LOW && !ph_ff[0]) begin
               sr_mid = {sr_ff[6:0], sda_in};
            end
            sr_in = sr_mid;
            if (ph_ff == ph_last) begin
               if (cmd_ff == CMD_START) begin
                  clk_in = 1'b0;
               end
               if (cmd_ff == CMD_READ) begin
                  rx_in = sr_mid;
               end
               cmd_in = CMD_IDLE;
               ph_in  = '0;
               done   = 1'b1;
            end else begin
               ph_in = ph_nx;
               unique case (cmd_ff)
                  CMD_START: begin
                     dat_in = 1'b0;
                  end
                  CMD_STOP: begin
                     dat_in = 1'b1;
                  end
                  CMD_WRITE: begin
                     if (ph_nx < WR_ACK_LOW) begin
                        case (WR_SUB[ph_nx])
                           SUB_LOW:  clk_in = 1'b0;
                           SUB_DATA: dat_in = sr_mid[7];
                           SUB_HIGH: begin
                              clk_in = 1'b1;
                              sr_in  = {sr_mid[6:0], 1'b0};
                           end
                           default: clk_in = clk_ff;
                        endcase
                     end else if (ph_nx == WR_ACK_LOW) begin
                        clk_in = 1'b0;
                        dat_in = 1'b1;
                     end else if (ph_nx == WR_ACK_HIGH) begin
                        clk_in = 1'b1;
                     end else begin
                        clk_in = 1'b0;
                     end
                  end
                  CMD_READ: begin
                     if (ph_nx < RD_ACK_LOW) begin
                        if (!ph_nx[0]) begin
                           clk_in = 1'b1;
                           dat_in = 1'b1;
                        end else begin
                           clk_in = 1'b0;
                        end
                     end else if (ph_nx == RD_ACK_LOW) begin
                        clk_in = 1'b0;
                        dat_in = hold_ff;
                     end else if (ph_nx == RD_ACK_HIGH) begin
                        clk_in = 1'b1;
                     end else begin
                        clk_in = 1'b0;
                        dat_in = 1'b1;
                     end
                  end
                  default: begin
                     ph_in = ph_ff;
                  end
               endcase
            end
         end
      end

      rsp_next.scl_level = clk_in;
      rsp_next.sda_level = dat_in;
      rsp_next.busy_res  = (cmd_in != CMD_IDLE);
      rsp_next.done_res  = done;
      rsp_next.rx_byte   = rx_in;
      rsp_next.ack_seen  = ack_in;
   end

endmodule

// File: rtl/i2cme_rsp_reg.sv
// Result register: holds one response until the consumer takes it.
module i2cme_rsp_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  i2cme_pkg::rsp_type rsp_in,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic              can_load,
   output i2cme_pkg::rsp_type rsp_out
);
   import i2cme_pkg::*;

   logic    valid_ff;
   rsp_type data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= rsp_in;
      end
   end

   assign can_load  = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_out   = data_ff;

endmodule

// File: rtl/i2c_master_byte_engine_top.sv
// A response is valid the cycle after its request is accepted. Throughput:
// one request per cycle unless a response waits; each request is one bus
// tick of the phase sequencer, and the result register frees itself as it
// is drained. Reset: synchronous; lines released, sequencer idle, phase
// length 5, no response pending. Top level of the I2C master byte engine.
module i2c_master_byte_engine_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_action,
   input  logic [7:0] req_tx_byte,
   input  logic       req_ack_to_send,
   input  logic       req_sda_in,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_scl_level,
   output logic       rsp_sda_level,
   output logic       rsp_busy_res,
   output logic       rsp_done_res,
   output logic [7:0] rsp_rx_byte,
   output logic       rsp_ack_seen,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [8:0] csr_wdata
);
   import i2cme_pkg::*;

   rsp_type rsp_next;
   rsp_type rsp_q;
   logic    can_load;
   logic    step_en;

   assign req_ready = can_load;
   assign step_en   = req_valid && can_load;
   assign csr_ready = 1'b1;

   i2cme_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step_en     (step_en),
      .csr_we      (csr_valid),
      .csr_wdata   (csr_wdata),
      .action      (req_action),
      .tx_byte     (req_tx_byte),
      .ack_to_send (req_ack_to_send),
      .sda_in      (req_sda_in),
      .rsp_next    (rsp_next)
   );

   i2cme_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (step_en),
      .rsp_in    (rsp_next),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .can_load  (can_load),
      .rsp_out   (rsp_q)
   );

   assign rsp_scl_level = rsp_q.scl_level;
   assign rsp_sda_level = rsp_q.sda_level;
   assign rsp_busy_res  = rsp_q.busy_res;
   assign rsp_done_res  = rsp_q.done_res;
   assign rsp_rx_byte   = rsp_q.rx_byte;
   assign rsp_ack_seen  = rsp_q.ack_seen;

endmodule

// File: rtl/i2cme_checker.sv
// Port-level checks for the I2C master byte engine, bound to the top level.
module i2cme_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_scl_level,
   input logic       rsp_sda_level,
   input logic       rsp_busy_res,
   input logic       rsp_done_res,
   input logic [7:0] rsp_rx_byte,
   input logic       rsp_ack_seen
);

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res)
      else $error("done reported while still busy");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty result register");

   a_drain_empties: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !req_valid |=> !rsp_valid)
      else $error("response repeated after it was taken");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rx_byte)
         && $stable(rsp_done_res) && $stable(rsp_scl_level) && $stable(rsp_sda_level)
         && $stable(rsp_busy_res) && $stable(rsp_ack_seen))
      else $error("stalled response changed");

endmodule

bind i2c_master_byte_engine_top i2cme_checker u_checker (.*);

// File: tb/i2c_master_byte_engine_top_tb.sv
// Testbench for the I2C master byte engine: predicted bus line states per tick.
module i2c_master_byte_engine_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import i2cme_pkg::*;

   localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
   localparam logic [2:0] ACT_UNUSED_HI = 3'd7;
   localparam int SDA_RANDOM = 2;
   localparam int BURST_MAX = 18;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] tx_byte;
      logic       ack_to_send;
      logic       sda_in;
   } tick_req_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [2:0] req_action = '0;
   logic [7:0] req_tx_byte = '0;
   logic       req_ack_to_send = 1'b0;
   logic       req_sda_in = 1'b1;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_scl_level;
   logic       rsp_sda_level;
   logic       rsp_busy_res;
   logic       rsp_done_res;
   logic [7:0] rsp_rx_byte;
   logic       rsp_ack_seen;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [8:0] csr_wdata = '0;

   tick_req_type tick_q[$];
   rsp_type      line_state_q[$];
   tick_req_type req_item;
   rsp_type      want;
   bit           req_holding = 1'b0;
   bit           jitter_on = 1'b1;
   int           send_gap = 0;
   int           stall_left = 0;
   int           mismatches = 0;
   int           rsp_seen = 0;

   // bus engine shadow state
   cmd_type    bus_cmd;
   logic [4:0] bus_phase;
   logic [8:0] bus_tick;
   logic [7:0] shifter;
   logic       ack_from_slave;
   logic       scl_q;
   logic       sda_q;
   logic       ack_for_read;
   logic [7:0] last_rx;
   logic [8:0] phase_len_cfg;

   i2c_master_byte_engine_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_tx_byte     (req_tx_byte),
      .req_ack_to_send (req_ack_to_send),
      .req_sda_in      (req_sda_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_scl_level   (rsp_scl_level),
      .rsp_sda_level   (rsp_sda_level),
      .rsp_busy_res    (rsp_busy_res),
      .rsp_done_res    (rsp_done_res),
      .rsp_rx_byte     (rsp_rx_byte),
      .rsp_ack_seen    (rsp_ack_seen),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [4:0] phase_count(input cmd_type c);
      case (c)
         CMD_START, CMD_STOP: return 5'd2;
         CMD_WRITE: return 5'd27;
         CMD_READ: return 5'd19;
         default: return 5'd1;
      endcase
   endfunction

   function automatic int phase_len();
      return (phase_len_cfg == 9'd0) ? 1 : int'(phase_len_cfg);
   endfunction

   function automatic void set_lines(input logic [4:0] ph);
      case (bus_cmd)
         CMD_START: begin
            if (ph == 5'd0) begin
               sda_q = 1'b1;
               scl_q = 1'b1;
            end else
               sda_q = 1'b0;
         end
         CMD_STOP: begin
            if (ph == 5'd0) begin
               sda_q = 1'b0;
               scl_q = 1'b1;
            end else
               sda_q = 1'b1;
         end
         CMD_WRITE: begin
            if (ph < 5'd24) begin
               case (ph % 5'd3)
                  5'd0: scl_q = 1'b0;
                  5'd1: sda_q = shifter[7];
                  default: begin
                     scl_q = 1'b1;
                     shifter = {shifter[6:0], 1'b0};
                  end
               endcase
            end else if (ph == 5'd24) begin
               scl_q = 1'b0;
               sda_q = 1'b1;
            end else if (ph == 5'd25)
               scl_q = 1'b1;
            else
               scl_q = 1'b0;
         end
         CMD_READ: begin
            if (ph < 5'd16) begin
               if (!ph[0]) begin
                  scl_q = 1'b1;
                  sda_q = 1'b1;
               end else
                  scl_q = 1'b0;
            end else if (ph == 5'd16) begin
               scl_q = 1'b0;
               sda_q = ack_for_read;
            end else if (ph == 5'd17)
               scl_q = 1'b1;
            else begin
               scl_q = 1'b0;
               sda_q = 1'b1;
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void sample_line(input logic [4:0] ph, input logic sda);
      if (bus_cmd == CMD_WRITE && ph == 5'd25)
         ack_from_slave = sda;
      else if (bus_cmd == CMD_READ && ph < 5'd16 && !ph[0])
         shifter = {shifter[6:0], sda};
   endfunction

   function automatic rsp_type next_line_state(input tick_req_type r);
      rsp_type o;
      logic    ends;
      ends = 1'b0;
      if (bus_cmd == CMD_IDLE) begin
         if (r.action >= CMD_START && r.action <= CMD_READ) begin
            bus_cmd = cmd_type'(r.action);
            bus_phase = '0;
            bus_tick = '0;
            shifter = (r.action == CMD_WRITE) ? r.tx_byte : 8'h00;
            if (r.action == CMD_READ)
               ack_for_read = r.ack_to_send;
            set_lines(5'd0);
         end
      end else begin
         bus_tick = bus_tick + 9'd1;
         if (int'(bus_tick) >= phase_len()) begin
            bus_tick = '0;
            sample_line(bus_phase, r.sda_in);
            if (bus_phase + 5'd1 >= phase_count(bus_cmd)) begin
               if (bus_cmd == CMD_START)
                  scl_q = 1'b0;
               else if (bus_cmd == CMD_READ)
                  last_rx = shifter;
               bus_cmd = CMD_IDLE;
               bus_phase = '0;
               ends = 1'b1;
            end else begin
               bus_phase = bus_phase + 5'd1;
               set_lines(bus_phase);
            end
         end
      end
      o.scl_level = scl_q;
      o.sda_level = sda_q;
      o.busy_res = (bus_cmd != CMD_IDLE);
      o.done_res = ends;
      o.rx_byte = last_rx;
      o.ack_seen = ack_from_slave;
      return o;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_holding = 1'b0;
         send_gap = 0;
         bus_cmd = CMD_IDLE;
         bus_phase = '0;
         bus_tick = '0;
         shifter = '0;
         ack_from_slave = 1'b1;
         scl_q = 1'b1;
         sda_q = 1'b1;
         ack_for_read = 1'b0;
         last_rx = '0;
         phase_len_cfg = 9'd5;
      end else begin
         if (req_valid && req_ready) begin
            line_state_q.push_back(next_line_state(req_item));
            req_holding = 1'b0;
         end
         if (!req_holding) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (jitter_on && tick_q.size() != 0 && $urandom_range(0, 7) == 0) begin
               send_gap = int'($urandom_range(1, BURST_MAX)) - 1;
               req_valid <= 1'b0;
            end else if (tick_q.size() != 0) begin
               req_item = tick_q.pop_front();
               req_holding = 1'b1;
               req_valid <= 1'b1;
               req_action <= req_item.action;
               req_tx_byte <= req_item.tx_byte;
               req_ack_to_send <= req_item.ack_to_send;
               req_sda_in <= req_item.sda_in;
            end else
               req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_seen++;
            if (line_state_q.size() == 0) begin
               if (mismatches < 10)
                  $display("response %0d arrived with no request outstanding", rsp_seen);
               mismatches++;
            end else begin
               want = line_state_q.pop_front();
               if (rsp_scl_level !== want.scl_level || rsp_sda_level !== want.sda_level ||
                   rsp_busy_res !== want.busy_res || rsp_done_res !== want.done_res ||
                   rsp_rx_byte !== want.rx_byte || rsp_ack_seen !== want.ack_seen) begin
                  if (mismatches < 10) begin
                     $display("response %0d: expected scl %b sda %b busy %b done %b rx %h ack %b",
                              rsp_seen, want.scl_level, want.sda_level, want.busy_res,
                              want.done_res, want.rx_byte, want.ack_seen);
                     $display("   actual scl %b sda %b busy %b done %b rx %h ack %b",
                              rsp_scl_level, rsp_sda_level, rsp_busy_res, rsp_done_res,
                              rsp_rx_byte, rsp_ack_seen);
                  end
                  mismatches++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (jitter_on && $urandom_range(0, 7) == 0) begin
            stall_left = int'($urandom_range(1, BURST_MAX)) - 1;
            rsp_ready <= 1'b0;
         end else
            rsp_ready <= 1'b1;
      end
   end

   task automatic drain();
      do @(posedge clock);
      while (tick_q.size() != 0 || req_holding || line_state_q.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_phase_ticks(input logic [8:0] ticks);
      csr_valid <= 1'b1;
      csr_wdata <= ticks;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      phase_len_cfg = ticks;
   endtask

   // queue one request, then ticks covering every phase of the command it starts
   task automatic push_cmd(input logic [2:0] act, input logic [7:0] tx, input logic ack,
                           input int sda_sel);
      tick_req_type t;
      int           n;
      t.action = act;
      t.tx_byte = tx;
      t.ack_to_send = ack;
      t.sda_in = (sda_sel == SDA_RANDOM) ? 1'($urandom) : 1'(sda_sel);
      tick_q.push_back(t);
      n = (act >= CMD_START && act <= CMD_READ) ?
          int'(phase_count(cmd_type'(act))) * phase_len() : 0;
      repeat (n) begin
         t.action = 3'($urandom_range(0, ACT_UNUSED_HI));
         t.tx_byte = 8'($urandom);
         t.ack_to_send = 1'($urandom);
         t.sda_in = (sda_sel == SDA_RANDOM) ? 1'($urandom) : 1'(sda_sel);
         tick_q.push_back(t);
      end
   endtask

   task automatic run_random(input logic [8:0] ticks, input int count, input bit jitter);
      tick_req_type t;
      int           r;
      set_phase_ticks(ticks);
      jitter_on = jitter;
      repeat (count) begin
         r = $urandom_range(0, 19);
         if (r < 13)
            t.action = CMD_IDLE;
         else if (r < 19)
            t.action = 3'($urandom_range(CMD_START, CMD_READ));
         else
            t.action = 3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
         t.tx_byte = 8'($urandom);
         t.ack_to_send = 1'($urandom);
         t.sda_in = 1'($urandom);
         tick_q.push_back(t);
      end
      // let any command in flight run out before the next register write
      repeat (int'(phase_count(CMD_WRITE)) * phase_len()) begin
         t.action = CMD_IDLE;
         t.tx_byte = 8'($urandom);
         t.ack_to_send = 1'($urandom);
         t.sda_in = 1'($urandom);
         tick_q.push_back(t);
      end
      drain();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      set_phase_ticks(9'd1);
      push_cmd(CMD_IDLE, 8'h00, 1'b0, 0);
      push_cmd(ACT_UNUSED_LO, 8'hFF, 1'b1, 1);
      push_cmd(ACT_UNUSED_LO + 3'd1, 8'h00, 1'b0, 0);
      push_cmd(ACT_UNUSED_HI, 8'hFF, 1'b1, 1);
      push_cmd(CMD_START, 8'h5A, 1'b0, SDA_RANDOM);
      push_cmd(CMD_WRITE, 8'hFF, 1'b0, 0);
      push_cmd(CMD_WRITE, 8'h00, 1'b1, 1);
      push_cmd(CMD_WRITE, 8'hA5, 1'b0, SDA_RANDOM);
      push_cmd(CMD_READ, 8'h00, 1'b0, 1);
      push_cmd(CMD_READ, 8'hFF, 1'b1, 0);
      push_cmd(CMD_READ, 8'h3C, 1'b1, SDA_RANDOM);
      push_cmd(CMD_STOP, 8'hC3, 1'b0, SDA_RANDOM);
      drain();
      run_random(9'd0, 80, 1'b1);
      run_random(9'd2, 80, 1'b1);
      run_random(9'd3, 60, 1'b0);
      run_random(9'd5, 80, 1'b1);
      run_random(9'd1, 80, 1'b1);
      set_phase_ticks(9'd256);
      push_cmd(CMD_STOP, 8'($urandom), 1'($urandom), SDA_RANDOM);
      drain();
      run_random(9'd4, 60, 1'b0);
      if (mismatches == 0 && line_state_q.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #1_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
